>>> design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define NPAD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Check a property on every rising edge, reset included.
`define NPAD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) else $error("%m: check failed");

`endif

>>> design/npad_pkg.sv
// ----------------------------------------------------------------------------
// npad_pkg
// Types, register indexes and constants of the annular disk nearest point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package npad_pkg;

    // Register indexes of the configuration port
    localparam logic [3:0] CFG_CENTRE_X = 4'd0;
    localparam logic [3:0] CFG_CENTRE_Y = 4'd1;
    localparam logic [3:0] CFG_CENTRE_Z = 4'd2;
    localparam logic [3:0] CFG_AXIS_X   = 4'd3;
    localparam logic [3:0] CFG_AXIS_Y   = 4'd4;
    localparam logic [3:0] CFG_AXIS_Z   = 4'd5;
    localparam logic [3:0] CFG_INNER    = 4'd6;
    localparam logic [3:0] CFG_OUTER    = 4'd7;

    // Fixed point limits
    localparam logic signed [31:0] AXIS_ONE     = 32'sd1073741824;
    localparam logic signed [31:0] AXIS_ONE_NEG = -32'sd1073741824;
    localparam logic signed [36:0] PAR_HI       = 37'sd8589934591;
    localparam logic signed [36:0] PAR_LO       = -37'sd8589934591;
    localparam logic signed [33:0] COORD_HI     = 34'sd2147483647;
    localparam logic signed [33:0] COORD_LO     = -34'sd2147483648;
    localparam logic [30:0]        OUTER_RESET  = 31'd65536;

    // Pipeline depths
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int PRE_STAGES  = 9;
    localparam int POST_STAGES = 5;

    typedef struct packed {
        logic [2:0][31:0] centre;
        logic [2:0][31:0] axis;
        logic [30:0]      inner;
        logic [30:0]      outer;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] smp;
        logic [63:0]      maxd;
    } t_base;

    typedef struct packed {
        logic [2:0][31:0] w;
        logic [2:0]       s;
        t_base            base;
    } t_sq_side;

    typedef struct packed {
        logic [31:0] m;
        logic [2:0]  s;
        logic [2:0]  neg;
        t_base       base;
    } t_dv_side;

endpackage

`default_nettype wire

>>> design/npad_cfg.sv
// ----------------------------------------------------------------------------
// npad_cfg
// Disk configuration registers written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module npad_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [3:0]    i_cfg_addr,
    input  wire logic [31:0]   i_cfg_data,
    output npad_pkg::t_cfg     o_cfg
);

    npad_pkg::t_cfg r_cfg;
    logic signed [31:0] w_axis;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    // Saturate the written axis component to plus or minus one
    always_comb begin
        if ($signed(i_cfg_data) > npad_pkg::AXIS_ONE) begin
            w_axis = npad_pkg::AXIS_ONE;
        end else if ($signed(i_cfg_data) < npad_pkg::AXIS_ONE_NEG) begin
            w_axis = npad_pkg::AXIS_ONE_NEG;
        end else begin
            w_axis = $signed(i_cfg_data);
        end
    end

    // Write one register per request, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre <= '0;
            r_cfg.axis   <= {npad_pkg::AXIS_ONE, 32'd0, 32'd0};
            r_cfg.inner  <= '0;
            r_cfg.outer  <= npad_pkg::OUTER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                npad_pkg::CFG_CENTRE_X: r_cfg.centre[0] <= i_cfg_data;
                npad_pkg::CFG_CENTRE_Y: r_cfg.centre[1] <= i_cfg_data;
                npad_pkg::CFG_CENTRE_Z: r_cfg.centre[2] <= i_cfg_data;
                npad_pkg::CFG_AXIS_X:   r_cfg.axis[0]   <= w_axis;
                npad_pkg::CFG_AXIS_Y:   r_cfg.axis[1]   <= w_axis;
                npad_pkg::CFG_AXIS_Z:   r_cfg.axis[2]   <= w_axis;
                npad_pkg::CFG_INNER:    r_cfg.inner     <= i_cfg_data[30:0];
                npad_pkg::CFG_OUTER:    r_cfg.outer     <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/npad_sqrt.sv
// ----------------------------------------------------------------------------
// npad_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module npad_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire logic [63:0]    i_rad,
    input  npad_pkg::t_sq_side  i_side,
    output logic                o_vld,
    output logic [31:0]         o_root,
    output npad_pkg::t_sq_side  o_side
);

    localparam int N = npad_pkg::SQRT_STEPS;

    logic               r_vld  [N];
    logic [33:0]        r_rem  [N];
    logic [31:0]        r_root [N];
    logic [63:0]        r_x    [N];
    npad_pkg::t_sq_side r_side [N];

    for (genvar j = 0; j < N; j++) begin : g_st
        logic               p_vld;
        logic [33:0]        p_rem;
        logic [31:0]        p_root;
        logic [63:0]        p_x;
        npad_pkg::t_sq_side p_side;
        logic [35:0]        t_sh;
        logic [35:0]        t_tr;
        logic [33:0]        n_rem;
        logic [31:0]        n_root;

        if (j == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_rad;
            assign p_side = i_side;
        end else begin : g_rest
            assign p_vld  = r_vld[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
            assign p_x    = r_x[j-1];
            assign p_side = r_side[j-1];
        end

        // Bring in two radicand bits and try the next root bit
        always_comb begin
            t_sh = {p_rem, p_x[63:62]};
            t_tr = {2'b00, p_root, 2'b01};
            if (t_sh >= t_tr) begin
                n_rem  = 34'(t_sh - t_tr);
                n_root = {p_root[30:0], 1'b1};
            end else begin
                n_rem  = t_sh[33:0];
                n_root = {p_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
            r_x[j]    <= {p_x[61:0], 2'b00};
            r_side[j] <= p_side;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

endmodule

`default_nettype wire

>>> design/npad_div.sv
// ----------------------------------------------------------------------------
// npad_div
// Three-lane pipelined restoring divider: |w| * 2^30 / m, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module npad_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire logic [2:0][31:0] i_mag,
    input  npad_pkg::t_dv_side  i_side,
    output logic                o_vld,
    output logic [2:0][30:0]    o_q,
    output npad_pkg::t_dv_side  o_side
);

    localparam int N = npad_pkg::DIV_STEPS;

    logic               r_vld  [N];
    logic [2:0][31:0]   r_rem  [N];
    logic [2:0][30:0]   r_bits [N];
    logic [2:0][30:0]   r_q    [N];
    npad_pkg::t_dv_side r_side [N];

    for (genvar j = 0; j < N; j++) begin : g_st
        logic               p_vld;
        logic [2:0][31:0]   p_rem;
        logic [2:0][30:0]   p_bits;
        logic [2:0][30:0]   p_q;
        npad_pkg::t_dv_side p_side;
        logic [2:0][31:0]   n_rem;
        logic [2:0][30:0]   n_q;
        logic [2:0][32:0]   t_sh;

        if (j == 0) begin : g_first
            // Top quotient bits are known zero: start from |w| >> 1
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign p_rem[l]  = {1'b0, i_mag[l][31:1]};
                assign p_bits[l] = {i_mag[l][0], 30'd0};
            end
            assign p_vld  = i_vld;
            assign p_q    = '0;
            assign p_side = i_side;
        end else begin : g_rest
            assign p_vld  = r_vld[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_bits = r_bits[j-1];
            assign p_q    = r_q[j-1];
            assign p_side = r_side[j-1];
        end

        // Shift in one numerator bit per lane and subtract when it fits
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                t_sh[l] = {p_rem[l], p_bits[l][30]};
                if (t_sh[l] >= {1'b0, p_side.m}) begin
                    n_rem[l] = 32'(t_sh[l] - {1'b0, p_side.m});
                    n_q[l]   = {p_q[l][29:0], 1'b1};
                end else begin
                    n_rem[l] = t_sh[l][31:0];
                    n_q[l]   = {p_q[l][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_q[j]    <= n_q;
            r_side[j] <= p_side;
            for (int l = 0; l < 3; l++) begin
                r_bits[j][l] <= {p_bits[l][29:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_q    = r_q[N-1];
    assign o_side = r_side[N-1];

endmodule

`default_nettype wire

>>> design/nearest_point_on_annular_disk.sv
// ----------------------------------------------------------------------------
// nearest_point_on_annular_disk
// Closest point on a flat annular disk to a stream of 3D sample points.
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+---------------------------
//   request   | in        | start, busy             | sample_x/y/z, max_dist_sq
//   result    | out       | o_valid strobe, 1 cycle | near_x/y/z, hit
//   config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_addr, i_cfg_data
//
// One request enters every cycle; busy stays low. Each result passes through
// 9 projection stages, 32 square root stages, 31 divider stages and 5
// scaling/distance stages. Synchronous active-low reset clears all valid
// bits and loads the default disk. The result side cannot stall, so the
// pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nearest_point_on_annular_disk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_sample_x,
    input  wire logic [31:0] i_sample_y,
    input  wire logic [31:0] i_sample_z,
    input  wire logic [63:0] i_max_dist_sq,
    output logic             o_valid,
    output logic [31:0]      o_near_x,
    output logic [31:0]      o_near_y,
    output logic [31:0]      o_near_z,
    output logic             o_hit,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);

    localparam int LAT = npad_pkg::PRE_STAGES + npad_pkg::SQRT_STEPS
                       + npad_pkg::DIV_STEPS + npad_pkg::POST_STAGES;

    npad_pkg::t_cfg cfg;
    logic           acc;
    logic [2:0][31:0] w_smp;

    assign busy  = 1'b0;
    assign acc   = start && !busy;
    assign w_smp = {i_sample_z, i_sample_y, i_sample_x};

    npad_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ---------------- projection onto the disk plane ----------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    npad_pkg::t_base r1_b, r2_b, r3_b, r4_b, r5_b, r6_b;
    logic signed [32:0] r1_d [3];
    logic signed [32:0] r2_d [3];
    logic signed [32:0] r3_d [3];
    logic signed [32:0] r4_d [3];
    logic signed [64:0] r2_prod [3];
    logic signed [33:0] r3_par;
    logic signed [65:0] r4_pq [3];
    logic signed [35:0] r5_v_i [3];
    logic signed [35:0] r6_v_i [3];
    logic [34:0]        r6_abs [3];
    npad_pkg::t_sq_side r7_side, r8_side, r9_side;
    logic [63:0]        r8_sq [3];
    logic [63:0]        r9_sum;

    logic signed [36:0] n_sum;
    logic [2:0]         n_s;
    logic [2:0]         n_si [3];

    // Advance the valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v} <= '0;
        end else begin
            {r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v}
                <= {acc, r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v};
        end
    end

    // Sum the axial components; stage 3 saturates the sum
    always_comb begin
        n_sum = 37'(r2_prod[0] >>> 30) + 37'(r2_prod[1] >>> 30)
              + 37'(r2_prod[2] >>> 30);
    end

    // Pick the common shift that brings every in-plane part under 2^31
    always_comb begin
        n_s = '0;
        for (int i = 0; i < 3; i++) begin
            priority if (r6_abs[i][34]) begin
                n_si[i] = 3'd4;
            end else if (r6_abs[i][33]) begin
                n_si[i] = 3'd3;
            end else if (r6_abs[i][32]) begin
                n_si[i] = 3'd2;
            end else if (r6_abs[i][31]) begin
                n_si[i] = 3'd1;
            end else begin
                n_si[i] = 3'd0;
            end
            if (n_si[i] > n_s) begin
                n_s = n_si[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1: offset from centre
        r1_b.smp  <= w_smp;
        r1_b.maxd <= i_max_dist_sq;
        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= $signed({w_smp[i][31], w_smp[i]})
                     - $signed({cfg.centre[i][31], cfg.centre[i]});
        end
        // Stage 2: offset times axis
        r2_b <= r1_b;
        for (int i = 0; i < 3; i++) begin
            r2_d[i]    <= r1_d[i];
            r2_prod[i] <= r1_d[i] * $signed(cfg.axis[i]);
        end
        // Stage 3: axial distance
        r3_b <= r2_b;
        for (int i = 0; i < 3; i++) begin
            r3_d[i] <= r2_d[i];
        end
        if (n_sum > npad_pkg::PAR_HI) begin
            r3_par <= 34'(npad_pkg::PAR_HI);
        end else if (n_sum < npad_pkg::PAR_LO) begin
            r3_par <= 34'(npad_pkg::PAR_LO);
        end else begin
            r3_par <= 34'(n_sum);
        end
        // Stage 4: axial part along each axis
        r4_b <= r3_b;
        for (int i = 0; i < 3; i++) begin
            r4_d[i]  <= r3_d[i];
            r4_pq[i] <= r3_par * $signed(cfg.axis[i]);
        end
        // Stage 5: in-plane vector
        r5_b <= r4_b;
        for (int i = 0; i < 3; i++) begin
            r5_v_i[i] <= 36'(r4_d[i]) - 36'(r4_pq[i] >>> 30);
        end
        // Stage 6: magnitudes for the range shift
        r6_b <= r5_b;
        for (int i = 0; i < 3; i++) begin
            r6_v_i[i] <= r5_v_i[i];
            r6_abs[i] <= (r5_v_i[i] < 0) ? 35'(-r5_v_i[i]) : 35'(r5_v_i[i]);
        end
        // Stage 7: scale down
        r7_side.base <= r6_b;
        r7_side.s    <= n_s;
        for (int i = 0; i < 3; i++) begin
            r7_side.w[i] <= 32'(r6_v_i[i] >>> n_s);
        end
        // Stage 8: squares
        r8_side <= r7_side;
        for (int i = 0; i < 3; i++) begin
            r8_sq[i] <= 64'($signed(r7_side.w[i]) * $signed(r7_side.w[i]));
        end
        // Stage 9: squared length
        r9_side <= r8_side;
        r9_sum  <= r8_sq[0] + r8_sq[1] + r8_sq[2];
    end

    // ---------------- length and direction ----------------
    logic               sq_v;
    logic [31:0]        sq_m;
    npad_pkg::t_sq_side sq_side;

    npad_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r9_v),
        .i_rad   (r9_sum),
        .i_side  (r9_side),
        .o_vld   (sq_v),
        .o_root  (sq_m),
        .o_side  (sq_side)
    );

    logic [2:0][31:0]   dv_mag;
    npad_pkg::t_dv_side dv_in;
    logic               dv_v;
    logic [2:0][30:0]   dv_q;
    npad_pkg::t_dv_side dv_side;

    // Split each scaled component into sign and magnitude
    always_comb begin
        dv_in.m    = sq_m;
        dv_in.s    = sq_side.s;
        dv_in.base = sq_side.base;
        for (int i = 0; i < 3; i++) begin
            dv_in.neg[i] = sq_side.w[i][31];
            dv_mag[i]    = sq_side.w[i][31] ? 32'(-sq_side.w[i]) : sq_side.w[i];
        end
    end

    npad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_v),
        .i_mag   (dv_mag),
        .i_side  (dv_in),
        .o_vld   (dv_v),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // ---------------- scale, clamp and distance ----------------
    logic ra_v, rb_v, rc_v, rd_v;
    npad_pkg::t_base    ra_b, rb_b, rc_b, rd_b;
    logic               ra_zero, rb_zero;
    logic [30:0]        ra_len;
    logic signed [31:0] ra_u [3];
    logic signed [63:0] rb_prod [3];
    logic [31:0]        rc_nr [3];
    logic [31:0]        rd_nr [3];
    logic [63:0]        rd_sq [3];
    logic [35:0]        n_mag;
    logic signed [33:0] n_p [3];
    logic signed [32:0] n_e [3];
    logic [31:0]        n_ae [3];
    logic [65:0]        n_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {ra_v, rb_v, rc_v, rd_v, o_valid} <= '0;
        end else begin
            {ra_v, rb_v, rc_v, rd_v, o_valid} <= {dv_v, ra_v, rb_v, rc_v, rd_v};
        end
    end

    assign n_mag = 36'(dv_side.m) << dv_side.s;

    // Centre plus the offset along the direction; stage C clamps it
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p[i] = 34'($signed(cfg.centre[i]));
            if (!rb_zero) begin
                n_p[i] = n_p[i] + 34'(rb_prod[i] >>> 30);
            end
        end
    end

    // Error to the sample per axis, and the summed squared distance
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i]  = $signed({rc_b.smp[i][31], rc_b.smp[i]})
                    - $signed({rc_nr[i][31], rc_nr[i]});
            n_ae[i] = (n_e[i] < 0) ? 32'(-n_e[i]) : 32'(n_e[i]);
        end
        n_dist = 66'(rd_sq[0]) + 66'(rd_sq[1]) + 66'(rd_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        // Stage A: clip the length, sign the direction
        ra_b    <= dv_side.base;
        ra_zero <= (dv_side.m == '0);
        if (n_mag < 36'(cfg.inner)) begin
            ra_len <= cfg.inner;
        end else if (n_mag > 36'(cfg.outer)) begin
            ra_len <= cfg.outer;
        end else begin
            ra_len <= n_mag[30:0];
        end
        for (int i = 0; i < 3; i++) begin
            ra_u[i] <= dv_side.neg[i] ? -$signed({1'b0, dv_q[i]})
                                      : $signed({1'b0, dv_q[i]});
        end
        // Stage B: direction times length
        rb_b    <= ra_b;
        rb_zero <= ra_zero;
        for (int i = 0; i < 3; i++) begin
            rb_prod[i] <= ra_u[i] * $signed({1'b0, ra_len});
        end
        // Stage C: add the centre and clamp
        rc_b <= rb_b;
        for (int i = 0; i < 3; i++) begin
            if (n_p[i] > npad_pkg::COORD_HI) begin
                rc_nr[i] <= 32'(npad_pkg::COORD_HI);
            end else if (n_p[i] < npad_pkg::COORD_LO) begin
                rc_nr[i] <= 32'(npad_pkg::COORD_LO);
            end else begin
                rc_nr[i] <= 32'(n_p[i]);
            end
        end
        // Stage D: squared error per axis; hold the point in step with it
        rd_b <= rc_b;
        for (int i = 0; i < 3; i++) begin
            rd_sq[i] <= 64'(n_ae[i]) * 64'(n_ae[i]);
            rd_nr[i] <= rc_nr[i];
        end
        // Stage E: saturated distance against the limit
        {o_near_z, o_near_y, o_near_x} <= {rd_nr[2], rd_nr[1], rd_nr[0]};
        if (n_dist[65:64] != 2'b00) begin
            o_hit <= 1'b0;
        end else begin
            o_hit <= (n_dist[63:0] < rd_b.maxd);
        end
    end

    `NPAD_ASSERT(a_latency, acc |-> ##LAT o_valid)
    `NPAD_ASSERT(a_no_orphan, o_valid |-> $past(acc, LAT))
    `NPAD_ASSERT(a_zero_limit, (acc && i_max_dist_sq == '0) |-> ##LAT !o_hit)
    `NPAD_ASSERT_ALWAYS(a_never_busy, !busy && o_cfg_ready)

endmodule

`default_nettype wire
